// ----- rtl/core/wff_pkg.sv -----
`timescale 1ns / 1ps

package wff_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
  localparam int PLEN_W      = $clog2(MAX_PATTERN + 1);
  localparam int MAX_NAME    = 256;
  localparam int CNT_W       = $clog2(MAX_NAME + 1);
  localparam int GRP_SIZE    = 8;
  localparam int GRP_CNT     = MAX_PATTERN / GRP_SIZE;
  localparam int CHAR_W      = 8;
  localparam int ETYPE_W     = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  typedef enum logic [1:0] {
    MODE_ALL  = 2'd0,
    MODE_FILE = 2'd1,
    MODE_DIR  = 2'd2,
    MODE_NAME = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEARCH_MODE    = 2'd0,
    REG_LEAD_WILDCARD  = 2'd1,
    REG_TRAIL_WILDCARD = 2'd2,
    REG_PATTERN_LEN    = 2'd3
  } reg_idx_t;

  localparam logic [ETYPE_W-1:0] ETYPE_FILE = 2'd0;
  localparam logic [ETYPE_W-1:0] ETYPE_DIR  = 2'd1;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic              name_en;
    logic              name_last;
    logic              load_en;
    logic [CHAR_W-1:0] char_code;
    logic [PLEN_W-1:0] load_ptr;
    logic [PLEN_W-1:0] plen;
  } cmd_t;

  // per-byte control carried down the compare pipeline
  typedef struct packed {
    logic               last;
    logic [ETYPE_W-1:0] etype;
    logic               len_ok;
    logic               exact_len;
    logic               ovf;
    logic               plen_zero;
  } ctl_t;

endpackage

// ----- rtl/core/wildcard_filename_filter.sv -----
`timescale 1ns / 1ps
// result: the last name byte passes the cell and group reduce registers, then sets out_valid
// throughput: one pattern or filename byte per cycle, set by the cell row and the two
//   compare stages behind it; input stalls only when both stages hold bytes and a result waits
// reset: synchronous active-low rst_n clears configuration registers, pointers, counters
//   and pipeline valid flags; pattern bytes stay undefined until loaded

module wildcard_filename_filter import wff_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic                  in_last,
  input  logic [ETYPE_W-1:0]    in_entry_type,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_selected,
  output logic                  out_name_overflow,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  mode_t             mode_r;
  logic              lead_r;
  logic              trail_r;
  logic [PLEN_W-1:0] plen_cfg_r;
  logic [PLEN_W-1:0] plen_eff;

  logic [PLEN_W-1:0] load_ptr_r;
  logic [PLEN_W-1:0] load_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [CNT_W-1:0]  cnt_inc;
  logic              ovf_r;
  logic              ovf_nxt;
  logic              ovf_new;

  logic              in_fire;
  logic              name_fire;
  logic              load_fire;
  logic              ready1;
  logic              ready2;
  logic              leave2;
  logic              out_free;
  logic              out_fire;

  logic              v1_r;
  logic              v1_nxt;
  logic              v2_r;
  logic              v2_nxt;
  ctl_t              ctl0;
  ctl_t              ctl1_r;
  ctl_t              ctl2_r;
  cmd_t              cmd;

  logic [CHAR_W-1:0]      win_chain [MAX_PATTERN+1];
  logic [MAX_PATTERN:0]   tok_chain;
  logic [MAX_PATTERN-1:0] tok_bits;
  logic [MAX_PATTERN-1:0] eq_bits;
  logic [MAX_PATTERN-1:0] pf_bits;
  logic [GRP_CNT-1:0]     grp_eq;
  logic [GRP_CNT-1:0]     grp_pf;

  logic tail;
  logic pref_fail_now;
  logic sub_found_now;
  logic match;
  logic sel;
  logic pref_fail_r;
  logic pref_fail_nxt;
  logic sub_found_r;
  logic sub_found_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_sel_r;
  logic out_ovf_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_ALL;
      lead_r     <= 1'b0;
      trail_r    <= 1'b0;
      plen_cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_SEARCH_MODE:    mode_r     <= mode_t'(cfg_wdata[1:0]);
        REG_LEAD_WILDCARD:  lead_r     <= cfg_wdata[0];
        REG_TRAIL_WILDCARD: trail_r    <= cfg_wdata[0];
        REG_PATTERN_LEN:    plen_cfg_r <= PLEN_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign plen_eff = (plen_cfg_r > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN) : plen_cfg_r;

  // handshake and pipeline flow
  assign out_fire  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign leave2    = !ctl2_r.last || out_free;
  assign ready2    = !v2_r || leave2;
  assign ready1    = !v1_r || ready2;
  assign in_stall  = !ready1;
  assign in_fire   = in_valid && ready1;
  assign name_fire = in_fire && in_action;
  assign load_fire = in_fire && !in_action;

  // pattern load pointer
  always_comb begin
    load_ptr_nxt = load_ptr_r;
    if (load_fire) begin
      if (load_ptr_r < PLEN_W'(MAX_PATTERN)) begin
        load_ptr_nxt = load_ptr_r + PLEN_W'(1);
      end
      if (in_last) begin
        load_ptr_nxt = '0;
      end
    end
  end

  // name length, saturating
  assign cnt_inc = (cnt_r < CNT_W'(MAX_NAME)) ? cnt_r + CNT_W'(1) : cnt_r;
  assign ovf_new = ovf_r || (cnt_r == CNT_W'(MAX_NAME));

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (name_fire) begin
      cnt_nxt = in_last ? '0 : cnt_inc;
      ovf_nxt = in_last ? 1'b0 : ovf_new;
    end
  end

  always_comb begin
    ctl0.last      = in_last;
    ctl0.etype     = in_entry_type;
    ctl0.len_ok    = ovf_new || (cnt_inc >= CNT_W'(plen_eff));
    ctl0.exact_len = !ovf_new && (cnt_inc == CNT_W'(plen_eff));
    ctl0.ovf       = ovf_new;
    ctl0.plen_zero = (plen_eff == '0);
  end

  always_comb begin
    cmd.name_en   = name_fire;
    cmd.name_last = in_last;
    cmd.load_en   = load_fire;
    cmd.char_code = in_char_code;
    cmd.load_ptr  = load_ptr_r;
    cmd.plen      = plen_eff;
  end

  // row of cells
  assign win_chain[MAX_PATTERN] = '0;
  assign tok_chain[0]           = 1'b0;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    wff_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (PAT_IDX_W'(j)),
      .cmd      (cmd),
      .stage_en (ready1),
      .win_in   (win_chain[j+1]),
      .tok_in   (tok_chain[j]),
      .win_out  (win_chain[j]),
      .tok_out  (tok_chain[j+1]),
      .eq_r     (eq_bits[j]),
      .pf_r     (pf_bits[j])
    );
  end

  assign tok_bits = tok_chain[MAX_PATTERN:1];

  wff_reduce u_reduce (
    .clk      (clk),
    .stage_en (ready2),
    .eq_bits  (eq_bits),
    .pf_bits  (pf_bits),
    .grp_eq_r (grp_eq),
    .grp_pf_r (grp_pf)
  );

  assign v1_nxt = ready1 ? name_fire : v1_r;
  assign v2_nxt = ready2 ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (ready1) begin
      ctl1_r <= ctl0;
    end
    if (ready2) begin
      ctl2_r <= ctl1_r;
    end
  end

  // final decision
  assign tail          = &grp_eq;
  assign pref_fail_now = pref_fail_r || (|grp_pf);
  assign sub_found_now = sub_found_r || (ctl2_r.len_ok && tail);

  always_comb begin
    if (ctl2_r.plen_zero) begin
      match = 1'b1;
    end else if (lead_r && trail_r) begin
      match = sub_found_now;
    end else if (lead_r) begin
      match = ctl2_r.len_ok && tail;
    end else if (trail_r) begin
      match = ctl2_r.len_ok && !pref_fail_now;
    end else begin
      match = ctl2_r.exact_len && tail;
    end
  end

  always_comb begin
    case (mode_r)
      MODE_ALL:  sel = 1'b1;
      MODE_FILE: sel = (ctl2_r.etype == ETYPE_FILE);
      MODE_DIR:  sel = (ctl2_r.etype == ETYPE_DIR);
      MODE_NAME: sel = match;
      default:   sel = 1'b0;
    endcase
  end

  always_comb begin
    pref_fail_nxt = pref_fail_r;
    sub_found_nxt = sub_found_r;
    if (v2_r && leave2) begin
      pref_fail_nxt = ctl2_r.last ? 1'b0 : pref_fail_now;
      sub_found_nxt = ctl2_r.last ? 1'b0 : sub_found_now;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (v2_r && ctl2_r.last && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && ctl2_r.last && out_free) begin
      out_sel_r <= sel;
      out_ovf_r <= ctl2_r.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_ptr_r  <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      pref_fail_r <= 1'b0;
      sub_found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      load_ptr_r  <= load_ptr_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      pref_fail_r <= pref_fail_nxt;
      sub_found_r <= sub_found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_selected      = out_sel_r;
  assign out_name_overflow = out_ovf_r;

`ifndef ASSERT_OFF
  a_tok_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_bits))
    else $error("prefix token in more than one cell");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == CNT_W'(MAX_NAME)))
    else $error("name overflow without saturated count");

  a_load_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    load_ptr_r <= PLEN_W'(MAX_PATTERN))
    else $error("pattern load pointer out of range");

  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |-> $past(v2_r && ctl2_r.last))
    else $error("result raised without a finished name");
`endif

endmodule

// ----- rtl/core/wff_cell.sv -----
`timescale 1ns / 1ps

module wff_cell import wff_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [PAT_IDX_W-1:0] cell_idx,
  input  cmd_t                 cmd,
  input  logic                 stage_en,
  input  logic [CHAR_W-1:0]    win_in,
  input  logic                 tok_in,
  output logic [CHAR_W-1:0]    win_out,
  output logic                 tok_out,
  output logic                 eq_r,
  output logic                 pf_r
);

  logic [CHAR_W-1:0] pat_r;
  logic [CHAR_W-1:0] win_r;
  logic [CHAR_W-1:0] win_nxt;
  logic              tok_r;
  logic              tok_nxt;
  logic              eq_nxt;
  logic              pf_nxt;
  logic [PLEN_W-1:0] idx_ext;
  logic              is_entry;
  logic              in_use;

  assign idx_ext  = PLEN_W'(cell_idx);
  // newest byte enters at the cell of the last pattern position, older bytes move down
  assign is_entry = (idx_ext + PLEN_W'(1)) == cmd.plen;
  assign in_use   = idx_ext < cmd.plen;
  assign win_nxt  = is_entry ? cmd.char_code : win_in;

  assign eq_nxt = !in_use || (win_nxt == pat_r);
  // token marks the name position that lines up with this pattern byte
  assign pf_nxt = cmd.name_en && tok_r && in_use && (cmd.char_code != pat_r);

  always_comb begin
    tok_nxt = tok_r;
    if (cmd.name_en) begin
      tok_nxt = cmd.name_last ? (cell_idx == '0) : tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= (cell_idx == '0);
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en && (cmd.load_ptr == idx_ext)) begin
      pat_r <= cmd.char_code;
    end
    if (cmd.name_en) begin
      win_r <= win_nxt;
    end
    if (stage_en) begin
      eq_r <= eq_nxt;
      pf_r <= pf_nxt;
    end
  end

  assign win_out = win_r;
  assign tok_out = tok_r;

endmodule

// ----- rtl/core/wff_reduce.sv -----
`timescale 1ns / 1ps

module wff_reduce import wff_pkg::*; (
  input  logic                   clk,
  input  logic                   stage_en,
  input  logic [MAX_PATTERN-1:0] eq_bits,
  input  logic [MAX_PATTERN-1:0] pf_bits,
  output logic [GRP_CNT-1:0]     grp_eq_r,
  output logic [GRP_CNT-1:0]     grp_pf_r
);

  logic [GRP_CNT-1:0] grp_eq_nxt;
  logic [GRP_CNT-1:0] grp_pf_nxt;

  always_comb begin
    for (int g = 0; g < GRP_CNT; g++) begin
      grp_eq_nxt[g] = &eq_bits[g*GRP_SIZE +: GRP_SIZE];
      grp_pf_nxt[g] = |pf_bits[g*GRP_SIZE +: GRP_SIZE];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      grp_eq_r <= grp_eq_nxt;
      grp_pf_r <= grp_pf_nxt;
    end
  end

endmodule
